// ----- design/dqme_pkg.sv -----
`timescale 1ns / 1ps
// dqme_pkg: shared constants, types and byte tables for the dns query encoder
// no dependencies; used by dqme_obuf, dqme_ctrl and the core
package dqme_pkg;

   localparam int MAX_LABEL_DEF = 63;
   localparam int MAX_NAME_DEF  = 255;

   localparam int HDR_LEN      = 12;
   localparam int TAIL_LEN     = 5;
   localparam int HDR_FLAGS_IDX = 2;
   localparam int HDR_QD_IDX    = 5;
   localparam int CNT_W        = 4;

   localparam logic [15:0] QDCOUNT_WORD = 16'h0100;
   localparam logic [15:0] QCLASS_IN    = 16'h0001;
   localparam logic [7:0]  RD_FLAG      = 8'h01;
   localparam logic [7:0]  DOT_CHAR     = 8'h2e;
   localparam logic [7:0]  NUL_CHAR     = 8'h00;
   localparam logic [7:0]  ZERO_BYTE    = 8'h00;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       error;
   } word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_DISPATCH,
      ST_CLOSE,
      ST_LENGTH,
      ST_READ,
      ST_LABEL,
      ST_ERR
   } state_type;

   function automatic logic [7:0] hdr_byte(input logic [CNT_W-1:0] idx);
      logic [7:0] b;
      b = ZERO_BYTE;
      if (idx == CNT_W'(HDR_FLAGS_IDX)) begin
         b = RD_FLAG;
      end else if (idx == CNT_W'(HDR_QD_IDX)) begin
         b = QDCOUNT_WORD[15:8];
      end
      return b;
   endfunction

   function automatic logic [7:0] tail_byte(input logic [2:0] idx, input logic [15:0] qt);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = ZERO_BYTE;
         3'd1: b = qt[15:8];
         3'd2: b = qt[7:0];
         3'd3: b = QCLASS_IN[15:8];
         3'd4: b = QCLASS_IN[7:0];
         default: b = ZERO_BYTE;
      endcase
      return b;
   endfunction

endpackage

// ----- design/dqme_ram.sv -----
`timescale 1ns / 1ps
// dqme_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dqme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dqme_obuf.sv -----
`timescale 1ns / 1ps
// dqme_obuf: one-word output register between the sequencer and the rsp channel
// depends on dqme_pkg for the word type
module dqme_obuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dqme_pkg::word_type in_word,
   output logic               in_ready,
   output logic               out_valid,
   output dqme_pkg::word_type out_word,
   input  logic               out_ready
);

   logic               valid_ff;
   logic               valid_in;
   dqme_pkg::word_type word_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         word_ff <= in_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- design/dqme_ctrl.sv -----
`timescale 1ns / 1ps
// dqme_ctrl: sequencer and name state; buffers labels in the label ram
// depends on dqme_pkg; drives dqme_ram and dqme_obuf
module dqme_ctrl #(
   parameter int MAX_LABEL = dqme_pkg::MAX_LABEL_DEF,
   parameter int MAX_NAME  = dqme_pkg::MAX_NAME_DEF,
   parameter int AW        = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [7:0]         req_ch,
   input  logic [15:0]        req_qtype,
   output logic               push_valid,
   output dqme_pkg::word_type push_word,
   input  logic               push_ready,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [7:0]         ram_wdata,
   output logic               ram_re,
   output logic [AW-1:0]      ram_raddr,
   input  logic [7:0]         ram_rdata
);

   localparam int LW = $clog2(MAX_LABEL + 1);
   localparam int NW = $clog2(MAX_NAME + 1);
   localparam int SW = ((NW > LW) ? NW : LW) + 2;
   localparam int CW = dqme_pkg::CNT_W;

   dqme_pkg::state_type state_ff, state_in;

   logic           op_ff, op_in;
   logic [7:0]     ch_ff, ch_in;
   logic [15:0]    qtype_ff, qtype_in;
   logic           err_ff, err_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]  idx_ff, idx_in;
   logic [LW-1:0]  lc_ff, lc_in;
   logic [NW-1:0]  nl_ff, nl_in;
   logic           inq_ff, inq_in;
   logic           ne_ff, ne_in;

   logic is_end, too_long, disp_emits, hdr_end, tail_end, lbl_end, store_ch;

   assign is_end   = (ch_ff == dqme_pkg::DOT_CHAR) || (ch_ff == dqme_pkg::NUL_CHAR);
   assign too_long = (lc_ff >= LW'(MAX_LABEL)) ||
                     ((SW'(nl_ff) + SW'(lc_ff) + SW'(3)) > SW'(MAX_NAME));
   assign disp_emits = op_ff ||
                       (!ne_ff && ((is_end && (lc_ff != '0)) || (!is_end && too_long)));
   assign hdr_end  = (cnt_ff == CW'(dqme_pkg::HDR_LEN - 1));
   assign tail_end = (cnt_ff == CW'(dqme_pkg::TAIL_LEN - 1));
   assign lbl_end  = (idx_ff == (lc_ff - LW'(1)));
   assign store_ch = (state_ff == dqme_pkg::ST_DISPATCH) && !op_ff && !ne_ff &&
                     !is_end && !too_long;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dqme_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = inq_ff ? dqme_pkg::ST_DISPATCH : dqme_pkg::ST_HEADER;
            end
         end
         dqme_pkg::ST_HEADER: begin
            if (push_ready && hdr_end) begin
               state_in = dqme_pkg::ST_DISPATCH;
            end
         end
         dqme_pkg::ST_DISPATCH: begin
            priority if (op_ff) begin
               state_in = dqme_pkg::ST_CLOSE;
            end else if (ne_ff) begin
               state_in = dqme_pkg::ST_IDLE;
            end else if (is_end) begin
               state_in = (lc_ff != '0) ? dqme_pkg::ST_LENGTH : dqme_pkg::ST_IDLE;
            end else begin
               state_in = too_long ? dqme_pkg::ST_ERR : dqme_pkg::ST_IDLE;
            end
         end
         dqme_pkg::ST_CLOSE: begin
            if (push_ready && tail_end) begin
               state_in = dqme_pkg::ST_IDLE;
            end
         end
         dqme_pkg::ST_LENGTH: begin
            if (push_ready) begin
               state_in = dqme_pkg::ST_READ;
            end
         end
         dqme_pkg::ST_READ: begin
            state_in = dqme_pkg::ST_LABEL;
         end
         dqme_pkg::ST_LABEL: begin
            if (push_ready) begin
               state_in = lbl_end ? dqme_pkg::ST_IDLE : dqme_pkg::ST_READ;
            end
         end
         dqme_pkg::ST_ERR: begin
            if (push_ready) begin
               state_in = dqme_pkg::ST_IDLE;
            end
         end
         default: state_in = dqme_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      push_word  = '{data: dqme_pkg::ZERO_BYTE, last: 1'b0, error: 1'b0};
      ram_re     = 1'b0;
      unique case (state_ff)
         dqme_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         dqme_pkg::ST_HEADER: begin
            push_valid = 1'b1;
            push_word  = '{data: dqme_pkg::hdr_byte(cnt_ff),
                           last: hdr_end && !disp_emits, error: 1'b0};
         end
         dqme_pkg::ST_DISPATCH: begin
         end
         dqme_pkg::ST_CLOSE: begin
            push_valid = 1'b1;
            push_word  = '{data: dqme_pkg::tail_byte(cnt_ff[2:0], qtype_ff),
                           last: tail_end, error: err_ff};
         end
         dqme_pkg::ST_LENGTH: begin
            push_valid = 1'b1;
            push_word  = '{data: 8'(lc_ff), last: 1'b0, error: 1'b0};
         end
         dqme_pkg::ST_READ: begin
            ram_re = 1'b1;
         end
         dqme_pkg::ST_LABEL: begin
            push_valid = 1'b1;
            push_word  = '{data: ram_rdata, last: lbl_end, error: 1'b0};
         end
         dqme_pkg::ST_ERR: begin
            push_valid = 1'b1;
            push_word  = '{data: dqme_pkg::ZERO_BYTE, last: 1'b1, error: 1'b1};
         end
         default: begin
         end
      endcase
   end

   assign ram_we    = store_ch;
   assign ram_waddr = lc_ff[AW-1:0];
   assign ram_wdata = ch_ff;
   assign ram_raddr = idx_ff[AW-1:0];

   // name state and item registers
   always_comb begin
      op_in    = op_ff;
      ch_in    = ch_ff;
      qtype_in = qtype_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      lc_in    = lc_ff;
      nl_in    = nl_ff;
      inq_in   = inq_ff;
      ne_in    = ne_ff;
      unique case (state_ff)
         dqme_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               ch_in    = req_ch;
               qtype_in = req_qtype;
               cnt_in   = '0;
               if (!inq_ff) begin
                  inq_in = 1'b1;
                  ne_in  = 1'b0;
                  lc_in  = '0;
                  nl_in  = '0;
               end
            end
         end
         dqme_pkg::ST_HEADER: begin
            if (push_ready) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         dqme_pkg::ST_DISPATCH: begin
            cnt_in = '0;
            idx_in = '0;
            if (op_ff) begin
               err_in = !ne_ff && (lc_ff != '0);
            end else if (!ne_ff && is_end && (lc_ff == '0)) begin
               ne_in = 1'b1;
            end else if (store_ch) begin
               lc_in = lc_ff + LW'(1);
            end
         end
         dqme_pkg::ST_CLOSE: begin
            if (push_ready) begin
               cnt_in = cnt_ff + CW'(1);
               if (tail_end) begin
                  inq_in = 1'b0;
                  ne_in  = 1'b0;
                  lc_in  = '0;
                  nl_in  = '0;
               end
            end
         end
         dqme_pkg::ST_LABEL: begin
            if (push_ready) begin
               if (lbl_end) begin
                  nl_in = NW'(SW'(nl_ff) + SW'(lc_ff) + SW'(1));
                  lc_in = '0;
               end else begin
                  idx_in = idx_ff + LW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqme_pkg::ST_IDLE;
         lc_ff    <= '0;
         nl_ff    <= '0;
         inq_ff   <= 1'b0;
         ne_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
         nl_ff    <= nl_in;
         inq_ff   <= inq_in;
         ne_ff    <= ne_in;
      end
      op_ff    <= op_in;
      ch_ff    <= ch_in;
      qtype_ff <= qtype_in;
      err_ff   <= err_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
   end

endmodule

// ----- design/dns_query_message_encoder_core.sv -----
`timescale 1ns / 1ps
// dns query message encoder: one name character or close per req word,
// query message bytes out one per rsp word; one item in flight at a time
// a query's first item is led by 12 header words, one per cycle while rsp_ready;
// a character that only buffers emits no word; a label flush emits the length byte,
// then each label byte as read from the label ram; close emits 5 words, one per cycle
// while rsp_ready; reset: synchronous, clears the name state, not the label ram
module dns_query_message_encoder_core #(
   parameter int MAX_LABEL = dqme_pkg::MAX_LABEL_DEF,
   parameter int MAX_NAME  = dqme_pkg::MAX_NAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_ch,
   input  logic [15:0] req_qtype,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_error
);

   localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

   logic               push_valid, push_ready;
   dqme_pkg::word_type push_word, out_word;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [7:0]         ram_wdata, ram_rdata;

   dqme_ctrl #(
      .MAX_LABEL (MAX_LABEL),
      .MAX_NAME  (MAX_NAME),
      .AW        (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_ch     (req_ch),
      .req_qtype  (req_qtype),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   dqme_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LABEL),
      .AW    (AW)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dqme_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_word   (push_word),
      .in_ready  (push_ready),
      .out_valid (rsp_valid),
      .out_word  (out_word),
      .out_ready (rsp_ready)
   );

   assign rsp_out_byte = out_word.data;
   assign rsp_last     = out_word.last;
   assign rsp_error    = out_word.error;

endmodule

// ----- design/dqme_checker.sv -----
`timescale 1ns / 1ps
// dqme_checker: port-level assertions for the dns query encoder
// bound to dns_query_message_encoder_core; no package dependency
module dqme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic [7:0]  req_ch,
   input logic [15:0] req_qtype,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic        rsp_error
);

   // out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   // one word at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a word while busy");

   // no new word mid-burst
   a_no_accept_mid_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("ready during an unfinished burst");

   // stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_error)))
      else $error("rsp word changed while stalled");

endmodule

bind dns_query_message_encoder_core dqme_checker u_dqme_checker (.*);
